// ===== design/etf_pkg.sv =====
// Shared types and constants for the edge timestamp FIFO.
// No dependencies; used by the top level.
package etf_pkg;

    localparam int TIME_W   = 32;
    localparam int ACK_W    = 8;
    localparam int LOST_W   = 8;
    localparam int STATUS_W = 8;
    localparam int RETX_W   = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int ENTRY_W  = TIME_W + 1;

    localparam logic [STATUS_W-1:0] ST_PENDING = 8'hFF;
    localparam logic [STATUS_W-1:0] ST_ACKED   = 8'hFE;
    localparam logic [LOST_W-1:0]   LOST_MAX   = 8'hFF;
    localparam logic [RETX_W-1:0]   RETX_RESET = 7'd10;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_ACK   = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_SEND  = 3'd3,
        MODE_START = 3'd4
    } t_mode;

    typedef enum logic {
        REG_INVERT = 1'b0,
        REG_RETX   = 1'b1
    } t_reg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SEND = 1'b1
    } t_state;

endpackage

// ===== design/etf_if.sv =====
// Valid/ready channel interfaces for the edge timestamp FIFO.
// Standalone; instantiated around the top level.
interface etf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic        pin_level;
    logic [31:0] timestamp;
    logic [7:0]  ack_amount;

    modport source (output valid, mode, pin_level, timestamp, ack_amount, input ready);
    modport sink (input valid, mode, pin_level, timestamp, ack_amount, output ready);
endinterface

interface etf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ack_total;
    logic [7:0]  overflow_seen;
    logic        event_valid;
    logic [31:0] event_time;
    logic        event_level;
    logic        last_of_report;

    modport source (output valid, ack_total, overflow_seen, event_valid, event_time,
                    event_level, last_of_report, input ready);
    modport sink (input valid, ack_total, overflow_seen, event_valid, event_time,
                  event_level, last_of_report, output ready);
endinterface

// ===== design/etf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/edge_timestamp_fifo_with_ack.sv =====
// Edge timestamp FIFO: top level. Uses etf_pkg, etf_if and etf_ram.
// Events live in a circular buffer in one RAM; a partial ack advances the head pointer, a full ack empties it.
//
// Every item except a send slot that starts a report leaves the block idle, and the next item is
// accepted in the following cycle. A send slot that reports N stored entries (or one overflow-only
// record) holds the block in the send state: while the sink keeps up, entries stream out of the RAM
// read port one per cycle into the output register, and input ready stays low until the final
// record is loaded. Sink stalls stretch the report. Configuration via the APB port: invert_level
// at 0x0, retransmit_ticks at 0x4; no clearing pass after reset.
module edge_timestamp_fifo_with_ack
    import etf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    etf_in_if.sink             i_in,
    etf_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;

    function automatic logic [PW-1:0] wrap_ptr(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        d = (s >= SW'(FIFO_DEPTH)) ? s - SW'(FIFO_DEPTH) : s;
        return d[PW-1:0];
    endfunction

    // configuration
    logic              r_invert;
    logic [RETX_W-1:0] r_retx;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_retx   <= RETX_RESET;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[2]))
                REG_INVERT: r_invert <= pwdata[0];
                REG_RETX:   r_retx   <= pwdata[RETX_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_INVERT: prdata = {{(PDATA_W-1){1'b0}}, r_invert};
            REG_RETX:   prdata = {{(PDATA_W-RETX_W){1'b0}}, r_retx};
            default:    prdata = '0;
        endcase
    end

    // state
    t_state              r_state, n_state;
    logic [PW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_total, n_total;
    logic [ACK_W-1:0]    r_ack_sum, n_ack_sum;
    logic [LOST_W-1:0]   r_lost, n_lost;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_prior, n_prior;
    logic [PW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]       r_left, n_left;
    logic [LOST_W-1:0]   r_ov, n_ov;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [ACK_W-1:0]  r_o_ack, n_o_ack;
    logic [LOST_W-1:0] r_o_ov, n_o_ov;
    logic              r_o_ev, n_o_ev;
    logic [TIME_W-1:0] r_o_time, n_o_time;
    logic              r_o_lvl, n_o_lvl;
    logic              r_o_last, n_o_last;

    logic               in_acc, out_free, lvl, st_mark;
    logic [CW-1:0]      amt;
    logic [STATUS_W-1:0] st_tmp;
    logic               ram_we;
    logic [PW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_q;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign lvl        = i_in.pin_level ^ r_invert;
    assign amt        = i_in.ack_amount[CW-1:0];

    assign ram_waddr = wrap_ptr(SW'(r_head) + SW'(r_total));
    assign ram_wdata = {lvl, i_in.timestamp};

    etf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_total     = r_total;
        n_ack_sum   = r_ack_sum;
        n_lost      = r_lost;
        n_status    = r_status;
        n_prior     = r_prior;
        n_rd_ptr    = r_rd_ptr;
        n_left      = r_left;
        n_ov        = r_ov;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_ack     = r_o_ack;
        n_o_ov      = r_o_ov;
        n_o_ev      = r_o_ev;
        n_o_time    = r_o_time;
        n_o_lvl     = r_o_lvl;
        n_o_last    = r_o_last;
        ram_we      = 1'b0;
        st_mark     = 1'b0;
        st_tmp      = r_status;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_in.mode))
                        MODE_TICK: begin
                            if (lvl != r_prior) begin
                                n_prior = lvl;
                                if (r_total >= CW'(FIFO_DEPTH)) begin
                                    if (r_lost != LOST_MAX) begin
                                        n_lost = r_lost + 1'b1;
                                    end
                                end else begin
                                    ram_we  = 1'b1;
                                    n_total = r_total + 1'b1;
                                    st_mark = 1'b1;
                                end
                            end
                            st_tmp   = st_mark ? ST_PENDING : r_status;
                            n_status = st_tmp[STATUS_W-1] ? st_tmp : st_tmp - 1'b1;
                        end
                        MODE_ACK: begin
                            n_ack_sum = r_ack_sum + i_in.ack_amount;
                            if (i_in.ack_amount >= ACK_W'(r_total)) begin
                                n_total  = '0;
                                n_status = ST_ACKED;
                            end else begin
                                n_head   = wrap_ptr(SW'(r_head) + SW'(amt));
                                n_total  = r_total - amt;
                                n_status = ST_PENDING;
                            end
                        end
                        MODE_STOP: begin
                            if (r_total != '0) begin
                                n_status = ST_PENDING;
                            end
                        end
                        MODE_SEND: begin
                            if (r_status == ST_PENDING && (r_total != '0 || r_lost != '0)) begin
                                n_lost   = '0;
                                n_status = {1'b0, r_retx};
                                n_ov     = r_lost;
                                n_left   = r_total;
                                n_rd_ptr = r_head;
                                n_state  = S_SEND;
                            end
                        end
                        MODE_START: begin
                            n_total   = '0;
                            n_ack_sum = '0;
                            n_lost    = '0;
                            n_status  = ST_ACKED;
                            n_prior   = lvl;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_ack     = r_ack_sum;
                    n_o_ov      = r_ov;
                    n_o_ev      = (r_left != '0);
                    n_o_time    = (r_left != '0) ? ram_q[TIME_W-1:0] : '0;
                    n_o_lvl     = (r_left != '0) ? ram_q[TIME_W] : 1'b0;
                    n_o_last    = (r_left <= CW'(1));
                    n_rd_ptr    = wrap_ptr(SW'(r_rd_ptr) + SW'(1));
                    n_left      = (r_left != '0) ? r_left - 1'b1 : '0;
                    if (r_left <= CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_total     <= '0;
            r_ack_sum   <= '0;
            r_lost      <= '0;
            r_status    <= ST_ACKED;
            r_prior     <= 1'b0;
            r_rd_ptr    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_total     <= n_total;
            r_ack_sum   <= n_ack_sum;
            r_lost      <= n_lost;
            r_status    <= n_status;
            r_prior     <= n_prior;
            r_rd_ptr    <= n_rd_ptr;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ov     <= n_ov;
        r_o_ack  <= n_o_ack;
        r_o_ov   <= n_o_ov;
        r_o_ev   <= n_o_ev;
        r_o_time <= n_o_time;
        r_o_lvl  <= n_o_lvl;
        r_o_last <= n_o_last;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.ack_total      = r_o_ack;
    assign o_out.overflow_seen  = r_o_ov;
    assign o_out.event_valid    = r_o_ev;
    assign o_out.event_time     = r_o_time;
    assign o_out.event_level    = r_o_lvl;
    assign o_out.last_of_report = r_o_last;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(FIFO_DEPTH))
        else $error("stored count exceeds depth");

    a_send_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_SEND) |=>
            (r_status[STATUS_W-1] == 1'b0 && r_lost == '0))
        else $error("report start did not arm countdown or clear lost count");

    a_fifo_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && $past(r_state) == S_SEND) |->
            ($stable(r_head) && $stable(r_total) && $stable(r_ack_sum)))
        else $error("FIFO changed during a report");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && out_free && r_left <= CW'(1)) |=>
            (r_state == S_IDLE && r_out_valid && r_o_last))
        else $error("final record did not end the report");

endmodule

// ===== test/edge_timestamp_fifo_with_ack_tb.sv =====
`timescale 1ns / 1ps
// Testbench for edge_timestamp_fifo_with_ack: directed and random tick/ack/stop/send/start traffic,
// checked against a built-in predictor of the event FIFO and its reports.
// Depends on etf_pkg, etf_if (etf_in_if, etf_out_if) and the top-level RTL.
module edge_timestamp_fifo_with_ack_tb;
    import etf_pkg::*;

    localparam int DEPTH           = 16;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 150;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SHOW_MAX        = 10;
    localparam int FLOOD_TICKS     = 40;
    localparam logic [2:0]        MODE_SPARE_LO = 3'd5;
    localparam logic [2:0]        MODE_SPARE_HI = 3'd7;
    localparam logic [RETX_W-1:0] RETX_MAX      = 7'd127;

    typedef struct packed {
        logic [ACK_W-1:0]  ack_total;
        logic [LOST_W-1:0] overflow_seen;
        logic              event_valid;
        logic [TIME_W-1:0] event_time;
        logic              event_level;
        logic              last_of_report;
    } t_record;

    class capture_tracker;
        bit                invert;
        bit [RETX_W-1:0]   retx_ticks;
        bit [TIME_W-1:0]   times [DEPTH];
        bit                levels [DEPTH];
        int unsigned       stored;
        bit [ACK_W-1:0]    ack_sum;
        bit [LOST_W-1:0]   lost;
        bit [STATUS_W-1:0] status;
        bit                prior;
        t_record           reports [$];
        int                errors;

        function new();
            invert     = 1'b0;
            retx_ticks = RETX_RESET;
            stored     = 0;
            ack_sum    = '0;
            lost       = '0;
            status     = ST_ACKED;
            prior      = 1'b0;
            errors     = 0;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= SHOW_MAX) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function string rec_text(t_record r);
            return $sformatf("ack_total=%0d overflow=%0d valid=%0b time=%h level=%0b last=%0b",
                             r.ack_total, r.overflow_seen, r.event_valid, r.event_time,
                             r.event_level, r.last_of_report);
        endfunction

        // Accepted input transaction: advance state, queue the report records it causes.
        function void take_item(logic [2:0] mode, logic pin, logic [TIME_W-1:0] ts,
                                logic [ACK_W-1:0] amt);
            bit      lvl;
            t_record rec;
            lvl = pin ^ invert;
            case (mode)
                MODE_TICK: begin
                    if (lvl != prior) begin
                        prior = lvl;
                        if (stored >= DEPTH) begin
                            if (lost != LOST_MAX) begin
                                lost++;
                            end
                        end else begin
                            times[stored]  = ts;
                            levels[stored] = lvl;
                            stored++;
                            status = ST_PENDING;
                        end
                    end
                    if (!status[STATUS_W-1]) begin
                        status = status - 1'b1;
                    end
                end
                MODE_ACK: begin
                    ack_sum = ack_sum + amt;
                    if (amt >= stored) begin
                        stored = 0;
                        status = ST_ACKED;
                    end else begin
                        for (int i = 0; i < stored - amt; i++) begin
                            times[i]  = times[i + amt];
                            levels[i] = levels[i + amt];
                        end
                        stored = stored - amt;
                        status = ST_PENDING;
                    end
                end
                MODE_STOP: begin
                    if (stored > 0) begin
                        status = ST_PENDING;
                    end
                end
                MODE_SEND: begin
                    if (status == ST_PENDING && (stored != 0 || lost != 0)) begin
                        rec.ack_total     = ack_sum;
                        rec.overflow_seen = lost;
                        lost   = '0;
                        status = {1'b0, retx_ticks};
                        if (stored == 0) begin
                            rec.event_valid    = 1'b0;
                            rec.event_time     = '0;
                            rec.event_level    = 1'b0;
                            rec.last_of_report = 1'b1;
                            reports.push_back(rec);
                        end else begin
                            for (int i = 0; i < stored; i++) begin
                                rec.event_valid    = 1'b1;
                                rec.event_time     = times[i];
                                rec.event_level    = levels[i];
                                rec.last_of_report = (i == stored - 1);
                                reports.push_back(rec);
                            end
                        end
                    end
                end
                MODE_START: begin
                    stored  = 0;
                    ack_sum = '0;
                    lost    = '0;
                    status  = ST_ACKED;
                    prior   = lvl;
                end
                default: ;
            endcase
        endfunction

        function void match_record(t_record got);
            t_record want;
            if (reports.size() == 0) begin
                fail($sformatf("unexpected result: %s", rec_text(got)));
                return;
            end
            want = reports.pop_front();
            if (got.ack_total !== want.ack_total || got.overflow_seen !== want.overflow_seen ||
                got.event_valid !== want.event_valid || got.event_time !== want.event_time ||
                got.event_level !== want.event_level ||
                got.last_of_report !== want.last_of_report) begin
                fail($sformatf("mismatch: expected %s, got %s", rec_text(want), rec_text(got)));
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    etf_in_if  in_if ();
    etf_out_if out_if ();

    capture_tracker    tracker;
    bit                calm_in  = 1'b0;
    bit                pin_now  = 1'b0;
    logic [TIME_W-1:0] stamp    = '0;
    int                idle_run = 0;

    edge_timestamp_fifo_with_ack #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 24) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        stamp = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom)
                                             : stamp + TIME_W'($urandom_range(1, 5000));
        return stamp;
    endfunction

    task automatic offer(input logic [2:0] mode, input logic pin, input logic [TIME_W-1:0] ts,
                         input logic [ACK_W-1:0] amt);
        int gap;
        gap = draw_gap(calm_in);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.mode       <= mode;
        in_if.pin_level  <= pin;
        in_if.timestamp  <= ts;
        in_if.ack_amount <= amt;
        do @(posedge clk); while (!(in_if.valid && in_if.ready));
        tracker.take_item(mode, pin, ts, amt);
    endtask

    task automatic tick(input logic pin);
        offer(MODE_TICK, pin, next_stamp(), ACK_W'($urandom));
        pin_now = pin;
    endtask

    // Write then read back over APB; the predictor takes the new value after the write.
    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        mask = (idx == REG_INVERT) ? PDATA_W'(1) : PDATA_W'({RETX_W{1'b1}});
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== (value & mask)) begin
            tracker.fail($sformatf("register %s read %h, expected %h", idx.name(), prdata,
                                   value & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_INVERT) begin
            tracker.invert = value[0];
        end else begin
            tracker.retx_ticks = value[RETX_W-1:0];
        end
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (tracker.reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic invert, input logic [RETX_W-1:0] retx);
        settle();
        write_reg(REG_INVERT, PDATA_W'(invert));
        write_reg(REG_RETX, PDATA_W'(retx));
    endtask

    task automatic random_phase(input int target);
        int  done;
        int  pick;
        int  burst;
        bit  raw;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                raw = ($urandom_range(0, 9) < 6) ? !pin_now : pin_now;
                tick(raw);
                done++;
            end else if (pick < 65) begin
                offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));
                done++;
            end else if (pick < 77) begin
                offer(MODE_ACK, 1'($urandom), $urandom,
                      ($urandom_range(0, 3) != 0) ? ACK_W'($urandom_range(0, tracker.stored + 1))
                                                  : ACK_W'($urandom));
                done++;
            end else if (pick < 82) begin
                offer(MODE_STOP, 1'($urandom), $urandom, ACK_W'($urandom));
                done++;
            end else if (pick < 85) begin
                raw = 1'($urandom);
                offer(MODE_START, raw, $urandom, ACK_W'($urandom));
                pin_now = raw;
                done++;
            end else if (pick < 93) begin
                burst = $urandom_range(4, 20);
                repeat (burst) tick(!pin_now);
                done += burst;
            end else begin
                offer(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), 1'($urandom), $urandom,
                      ACK_W'($urandom));
            end
        end
    endtask

    // Result side; holds off once for a long stretch in the middle of a report.
    initial begin : result_sink
        int      gap;
        int      taken;
        bit      calm;
        bit      held;
        bit      mid_report;
        t_record got;
        taken      = 0;
        calm       = 1'b0;
        held       = 1'b0;
        mid_report = 1'b0;
        out_if.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = draw_gap(calm);
            if (!held && taken >= 10 && mid_report) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!(out_if.valid && out_if.ready));
            got.ack_total      = out_if.ack_total;
            got.overflow_seen  = out_if.overflow_seen;
            got.event_valid    = out_if.event_valid;
            got.event_time     = out_if.event_time;
            got.event_level    = out_if.event_level;
            got.last_of_report = out_if.last_of_report;
            tracker.match_record(got);
            taken++;
            mid_report = !out_if.last_of_report;
        end
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin : stimulus
        tracker = new();
        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.mode       <= MODE_TICK;
        in_if.pin_level  <= 1'b0;
        in_if.timestamp  <= '0;
        in_if.ack_amount <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_INVERT, PDATA_W'(0));
        write_reg(REG_RETX, PDATA_W'(0));

        // directed: edges at time extremes, resend on expiry, partial/full ack, stop, spares
        offer(MODE_START, 1'b0, $urandom, ACK_W'($urandom));
        offer(MODE_TICK, 1'b1, 32'h0000_0000, 8'h00);
        offer(MODE_TICK, 1'b0, 32'hFFFF_FFFF, 8'hFF);
        offer(MODE_TICK, 1'b0, 32'h0000_0005, 8'h00);
        offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));
        offer(MODE_TICK, 1'b0, 32'h0000_0006, 8'h00);
        offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));
        offer(MODE_ACK, 1'($urandom), $urandom, 8'd1);
        offer(MODE_ACK, 1'($urandom), $urandom, 8'd254);
        offer(MODE_STOP, 1'($urandom), $urandom, ACK_W'($urandom));
        offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));
        offer(MODE_TICK, 1'b1, 32'h8000_0000, 8'h00);
        offer(MODE_STOP, 1'($urandom), $urandom, ACK_W'($urandom));
        offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
            offer(3'(m), 1'($urandom), $urandom, ACK_W'($urandom));
        end
        offer(MODE_ACK, 1'($urandom), $urandom, 8'd0);
        offer(MODE_START, 1'b1, $urandom, ACK_W'($urandom));
        offer(MODE_TICK, 1'b1, 32'h0000_0010, 8'h00);
        offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));

        // overflow flood: fill the FIFO and keep counting lost edges
        offer(MODE_START, 1'b0, $urandom, ACK_W'($urandom));
        pin_now = 1'b0;
        repeat (FLOOD_TICKS) tick(!pin_now);
        offer(MODE_SEND, 1'($urandom), $urandom, ACK_W'($urandom));
        offer(MODE_ACK, 1'($urandom), $urandom, 8'd255);

        set_config(1'b1, RETX_MAX);
        random_phase(ITEMS_PER_PHASE);
        set_config(1'b0, 7'd3);
        random_phase(ITEMS_PER_PHASE);
        set_config(1'b1, 7'd0);
        random_phase(ITEMS_PER_PHASE);
        set_config(1'b0, RETX_RESET);
        random_phase(ITEMS_PER_PHASE);

        settle();
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
